FILE: rtl/splitmix_binomial_sampler_defines.svh
// assertion macros for the splitmix binomial sampler
// no dependencies
`ifndef SPLITMIX_BINOMIAL_SAMPLER_DEFINES_SVH
`define SPLITMIX_BINOMIAL_SAMPLER_DEFINES_SVH
`define SBS_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define SBS_ASSERT_NXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

FILE: rtl/sbs_pkg.sv
// shared constants and types for the splitmix binomial sampler
// no dependencies
package sbs_pkg;
  localparam int ROLLS = 2048;
  localparam int COUNT_BITS = 48;
  localparam int HIST_DEPTH = 2 * ROLLS + 1;
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int ROLL_W = $clog2(ROLLS + 1);
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2 = 64'h94d049bb133111eb;
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_BASE = 2'd1;
  localparam logic [1:0] CFG_SEED = 2'd2;

  typedef struct packed {
    logic gen_step;
    logic mix_start;
    logic cnt_clear;
    logic cnt_take;
    logic flip_take;
    logic mem_rd;
    logic mem_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mix_done;
    logic base_neg;
  } sts_t;
endpackage

FILE: rtl/sbs_mix.sv
// one splitmix64 output plus modulo reduction, multi-cycle
// depends on sbs_pkg
module sbs_mix (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] state_in,
  input  logic [9:0]  modulus,
  output logic        done,
  output logic [63:0] raw,
  output logic [63:0] reduced
);
  logic [3:0]   phase;
  logic [63:0]  z;
  logic [127:0] pacc;
  logic [63:0]  rem;
  logic [6:0]   bitn;
  logic [63:0]  mpl;
  logic [64:0]  trial;

  // 16x32 partial products, eight per multiply
  assign trial = {rem, z[63]} - {55'd0, modulus};

  logic [2:0] sub;
  logic [63:0] ma;
  logic [31:0] mb;
  logic [47:0] prod;
  assign ma = z;
  assign mb = mpl[sub[0]*32 +: 32];
  assign prod = ma[sub[2:1]*16 +: 16] * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 4'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        4'd0: if (start) begin
          z <= state_in ^ (state_in >> 30);
          mpl <= sbs_pkg::MIX1;
          pacc <= '0;
          sub <= 3'd0;
          phase <= 4'd1;
        end
        4'd1, 4'd3: begin
          pacc <= pacc + (128'(prod) << (sub[2:1] * 16 + sub[0] * 32));
          sub <= sub + 3'd1;
          if (sub == 3'd7) phase <= phase + 4'd1;
        end
        4'd2: begin
          z <= pacc[63:0] ^ (pacc[63:0] >> 27);
          mpl <= sbs_pkg::MIX2;
          pacc <= '0;
          phase <= 4'd3;
        end
        4'd4: begin
          raw <= pacc[63:0] ^ (pacc[63:0] >> 31);
          z <= pacc[63:0] ^ (pacc[63:0] >> 31);
          rem <= '0;
          bitn <= 7'd0;
          phase <= (modulus == 10'd0) ? 4'd6 : 4'd5;
        end
        4'd5: begin
          if (!trial[64]) rem <= trial[63:0];
          else rem <= {rem[62:0], z[63]};
          z <= {z[62:0], 1'b0};
          bitn <= bitn + 7'd1;
          if (bitn == 7'd63) phase <= 4'd7;
        end
        4'd6: begin
          reduced <= raw;
          done <= 1'b1;
          phase <= 4'd0;
        end
        4'd7: begin
          reduced <= rem;
          done <= 1'b1;
          phase <= 4'd0;
        end
        default: phase <= 4'd0;
      endcase
    end
  end
endmodule

FILE: rtl/sbs_datapath.sv
// generator state, roll counter, histogram memory and result registers
// depends on sbs_pkg and sbs_mix
module sbs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sbs_pkg::cmd_t       cmd,
  output sbs_pkg::sts_t       sts,
  input  logic [1:0]          op,
  input  logic [12:0]         idx,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                clear_run,
  input  logic [sbs_pkg::HIST_AW-1:0] clear_addr,
  output logic [12:0]         sample_value,
  output logic [47:0]         bin_count,
  output logic [47:0]         draws_done
);
  logic [9:0]  modulus;
  logic signed [10:0] base;
  logic [63:0] gen_state;
  logic [sbs_pkg::ROLL_W-1:0] count;
  logic signed [12:0] sample;
  logic [47:0] total;
  logic [sbs_pkg::COUNT_BITS-1:0] hist [sbs_pkg::HIST_DEPTH];
  logic [sbs_pkg::COUNT_BITS-1:0] rd_data;
  logic [sbs_pkg::HIST_AW-1:0] addr;
  logic        addr_ok;
  logic        mdone;
  logic [63:0] raw, red;
  logic [10:0] mag;
  logic [13:0] bin;

  assign mag = base[10] ? 11'(-base) : 11'(base);
  assign bin = 14'(sample) + 14'(sbs_pkg::ROLLS);
  assign addr = (op == sbs_pkg::OP_DRAW) ? bin[sbs_pkg::HIST_AW-1:0]
                                          : idx[sbs_pkg::HIST_AW-1:0];
  assign addr_ok = (op == sbs_pkg::OP_DRAW) ? 1'b1
                                            : (idx < 13'(sbs_pkg::HIST_DEPTH));

  sbs_mix u_mix (.clk, .rst, .start(cmd.mix_start), .state_in(gen_state + sbs_pkg::GOLDEN),
                 .modulus, .done(mdone), .raw, .reduced(red));
  assign sts.mix_done = mdone;
  assign sts.base_neg = base[10];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 10'd11;
      base <= -11'sd10;
      gen_state <= '0;
      total <= '0;
    end else begin
      if (cfg_we && cfg_index == sbs_pkg::CFG_MODULUS) modulus <= cfg_data[9:0];
      if (cfg_we && cfg_index == sbs_pkg::CFG_BASE) base <= cfg_data[10:0];
      if (cfg_we && cfg_index == sbs_pkg::CFG_SEED) gen_state <= cfg_data;
      else if (cmd.gen_step) gen_state <= gen_state + sbs_pkg::GOLDEN;
      if (cmd.out_load && op == sbs_pkg::OP_DRAW && total != '1) total <= total + 48'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clear) begin
      count <= '0;
      sample <= '0;
    end else if (cmd.cnt_take) begin
      if (red < 64'(mag)) count <= count + 1'b1;
    end
    if (cmd.flip_take) begin
      if (base[10] && raw[0]) sample <= -13'(count);
      else sample <= 13'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data <= hist[addr];
    if (clear_run) hist[clear_addr] <= '0;
    else if (cmd.mem_wr && addr_ok) begin
      if (op == sbs_pkg::OP_DRAW) begin
        if (rd_data != '1) hist[addr] <= rd_data + 1'b1;
      end else if (op == sbs_pkg::OP_CLEAR) hist[addr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draws_done <= '0;
    end else if (cmd.out_load) begin
      draws_done <= (op == sbs_pkg::OP_DRAW && total != '1) ? total + 48'd1 : total;
      sample_value <= (op == sbs_pkg::OP_DRAW) ? sample : 13'd0;
      if (op == sbs_pkg::OP_DRAW)
        bin_count <= 48'((rd_data != '1) ? rd_data + 1'b1 : rd_data);
      else if ((op == sbs_pkg::OP_READ || op == sbs_pkg::OP_CLEAR) && addr_ok)
        bin_count <= 48'(rd_data);
      else bin_count <= '0;
    end
  end
endmodule

FILE: rtl/sbs_ctrl.sv
// sequencer for draws, bin reads and the post-reset clearing pass
// depends on sbs_pkg
module sbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    op,
  output logic          out_valid,
  input  logic          out_stall,
  output sbs_pkg::cmd_t cmd,
  input  sbs_pkg::sts_t sts,
  output logic          clear_run,
  output logic [sbs_pkg::HIST_AW-1:0] clear_addr
);
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_ROLL = 3'd2, S_FLIP = 3'd3,
                         S_RD = 3'd4, S_WR = 3'd5, S_OUT = 3'd6;
  logic [2:0] state;
  logic [sbs_pkg::ROLL_W-1:0] rolls;
  logic flip_wait;

  assign clear_run = (state == S_CLEAR);
  assign in_stall = !(state == S_IDLE) || out_valid;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.cnt_clear = 1'b1;
        cmd.mix_start = (op == sbs_pkg::OP_DRAW);
        cmd.gen_step = (op == sbs_pkg::OP_DRAW);
      end
      S_ROLL: if (sts.mix_done) begin
        cmd.cnt_take = 1'b1;
        cmd.mix_start = (rolls != sbs_pkg::ROLL_W'(sbs_pkg::ROLLS - 1)) || sts.base_neg;
        cmd.gen_step = (rolls != sbs_pkg::ROLL_W'(sbs_pkg::ROLLS - 1)) || sts.base_neg;
      end
      S_FLIP: if (sts.mix_done || !flip_wait) begin
        cmd.flip_take = 1'b1;
      end
      S_RD: cmd.mem_rd = 1'b1;
      S_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.out_load = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_addr <= '0;
      out_valid <= 1'b0;
      rolls <= '0;
      flip_wait <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == sbs_pkg::HIST_AW'(sbs_pkg::HIST_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && !in_stall) begin
          rolls <= '0;
          flip_wait <= 1'b0;
          state <= (op == sbs_pkg::OP_DRAW) ? S_ROLL : S_RD;
        end
        S_ROLL: if (sts.mix_done) begin
          if (rolls == sbs_pkg::ROLL_W'(sbs_pkg::ROLLS - 1)) begin
            flip_wait <= sts.base_neg;
            state <= S_FLIP;
          end
          rolls <= rolls + 1'b1;
        end
        S_FLIP: if (sts.mix_done || !flip_wait) state <= S_RD;
        S_RD: state <= S_WR;
        S_WR: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/splitmix_binomial_sampler.sv
// top level of the splitmix binomial sampler, one item at a time
// a roll is two multiplies as 8 partial products each and a 64-step restoring remainder,
// the remainder skipped with a zero modulus; a draw is ROLLS rolls plus one sign roll
// when base is negative
// bin reads go through a read and a write state; next beat taken once the result leaves
// after reset a clearing pass zeroes the whole histogram, no item is taken
module splitmix_binomial_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [12:0] bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [12:0] sample_value,
  output logic [47:0] bin_count,
  output logic [47:0] draws_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
`include "splitmix_binomial_sampler_defines.svh"
  sbs_pkg::cmd_t cmd;
  sbs_pkg::sts_t sts;
  logic clear_run;
  logic [sbs_pkg::HIST_AW-1:0] clear_addr;
  logic [1:0] op_q;
  logic [12:0] idx_q;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q <= operation;
      idx_q <= bin_index;
    end
  end

  sbs_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .op(operation), .out_valid,
                   .out_stall, .cmd, .sts, .clear_run, .clear_addr);
  sbs_datapath u_dp (.clk, .rst, .cmd, .sts, .op(cmd.cnt_clear ? operation : op_q),
                     .idx(idx_q), .cfg_we, .cfg_index, .cfg_data, .clear_run, .clear_addr,
                     .sample_value, .bin_count, .draws_done);

  `SBS_ASSERT_IMP(a_busy_stalls, clk, rst, clear_run, in_stall, "input taken during clear")
  `SBS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, $stable(bin_count), "result moved")
endmodule

FILE: dv/splitmix_binomial_sampler_tb.sv
// self-checking testbench for the splitmix binomial sampler: draws, bin reads and clears
// predicts every result beat in-line and compares it field by field
// depends on sbs_pkg and the splitmix_binomial_sampler rtl
module splitmix_binomial_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int IDLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 265;
  localparam int RANDOM_DRAWS = 3;

  typedef struct packed {
    logic signed [12:0] sample;
    logic [47:0]        count;
    logic [47:0]        total;
  } sample_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = sbs_pkg::OP_DRAW;
  logic [12:0] bin_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [12:0] sample_value;
  logic [47:0] bin_count;
  logic [47:0] draws_done;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = sbs_pkg::CFG_MODULUS;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic [9:0]         mod_reg;
  logic signed [10:0] base_reg;
  logic [63:0]        gen_state;
  logic [47:0]        hist [sbs_pkg::HIST_DEPTH];
  logic [47:0]        draw_total;
  sample_result_t     pending_results [$];
  int                 drawn_bins [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  bit                 stall_burst = 1'b0;

  splitmix_binomial_sampler i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] splitmix_next();
    logic [63:0] z;
    gen_state = gen_state + sbs_pkg::GOLDEN;
    z = gen_state;
    z = (z ^ (z >> 30)) * sbs_pkg::MIX1;
    z = (z ^ (z >> 27)) * sbs_pkg::MIX2;
    return z ^ (z >> 31);
  endfunction

  function automatic int draw_count();
    int mag;
    int cnt;
    logic [63:0] r;
    mag = (base_reg < 0) ? -int'(base_reg) : int'(base_reg);
    cnt = 0;
    for (int i = 0; i < sbs_pkg::ROLLS; i++) begin
      r = splitmix_next();
      if (mod_reg != 0) r = r % {54'd0, mod_reg};
      if (r < 64'(mag)) cnt++;
    end
    if (base_reg < 0) begin
      r = splitmix_next();
      if (r[0]) cnt = -cnt;
    end
    return cnt;
  endfunction

  function automatic sample_result_t predict_result(logic [1:0] op, logic [12:0] idx);
    sample_result_t res;
    int s;
    int b;
    res = '0;
    if (op == sbs_pkg::OP_DRAW) begin
      s = draw_count();
      b = s + sbs_pkg::ROLLS;
      if (hist[b] != '1) hist[b] = hist[b] + 1;
      res.count = hist[b];
      if (draw_total != '1) draw_total = draw_total + 1;
      res.sample = s[12:0];
      drawn_bins.push_back(b);
    end else if (op == sbs_pkg::OP_READ || op == sbs_pkg::OP_CLEAR) begin
      if (idx < sbs_pkg::HIST_DEPTH) begin
        res.count = hist[idx];
        if (op == sbs_pkg::OP_CLEAR) hist[idx] = '0;
      end
    end
    res.total = draw_total;
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    sample_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", 64'(bin_count), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (sample_value !== want.sample)
          report("sample_value", 64'(sample_value), 64'(want.sample));
        if (bin_count !== want.count) report("bin_count", 64'(bin_count), 64'(want.count));
        if (draws_done !== want.total) report("draws_done", 64'(draws_done), 64'(want.total));
      end
    end
  end

  // receiver stalls in bursts, with quiet stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_burst <= ~stall_burst;
    out_stall <= stall_burst && ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [12:0] idx);
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    bin_index = idx;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(predict_result(op, idx));
  endtask

  task automatic pause_sender(int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      operation = 2'($urandom);
      bin_index = 13'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      sbs_pkg::CFG_MODULUS: mod_reg = data[9:0];
      sbs_pkg::CFG_BASE: base_reg = data[10:0];
      sbs_pkg::CFG_SEED: gen_state = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = '0;
  endtask

  task automatic test_empty_reads();
    send_item(sbs_pkg::OP_READ, 13'd0);
    send_item(sbs_pkg::OP_READ, 13'd2048);
    send_item(sbs_pkg::OP_CLEAR, 13'd4096);
    send_item(sbs_pkg::OP_READ, 13'd4097);
    send_item(sbs_pkg::OP_CLEAR, 13'h1fff);
    send_item(OP_IDLE, 13'h0aaa);
  endtask

  task automatic test_default_draw();
    int b;
    send_item(sbs_pkg::OP_DRAW, 13'h1555);
    b = drawn_bins[$];
    send_item(sbs_pkg::OP_READ, 13'(b));
    send_item(sbs_pkg::OP_CLEAR, 13'(b));
    send_item(sbs_pkg::OP_READ, 13'(b));
    pause_sender(3);
    send_item(OP_IDLE, 13'h1fff);
  endtask

  task automatic test_extreme_draws();
    wait_idle();
    write_reg(sbs_pkg::CFG_MODULUS, 64'd0);
    write_reg(sbs_pkg::CFG_BASE, 64'h400);
    write_reg(sbs_pkg::CFG_SEED, '1);
    send_item(sbs_pkg::OP_DRAW, 13'd0);
    wait_idle();
    write_reg(sbs_pkg::CFG_MODULUS, 64'd1);
    write_reg(sbs_pkg::CFG_BASE, 64'd1023);
    send_item(sbs_pkg::OP_DRAW, 13'd0);
    send_item(sbs_pkg::OP_READ, 13'd4096);
    wait_idle();
    write_reg(sbs_pkg::CFG_MODULUS, 64'd1023);
    write_reg(sbs_pkg::CFG_BASE, 64'h400);
    write_reg(sbs_pkg::CFG_SEED, 64'h0123_4567_89ab_cdef);
    send_item(sbs_pkg::OP_DRAW, 13'd0);
    send_item(sbs_pkg::OP_READ, 13'd0);
    send_item(sbs_pkg::OP_CLEAR, 13'd4096);
    send_item(sbs_pkg::OP_READ, 13'd4096);
  endtask

  task automatic test_random_traffic();
    int draws_left;
    int burst;
    int pick;
    logic [12:0] idx;
    draws_left = RANDOM_DRAWS;
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 70 == 35) begin
        wait_idle();
        write_reg(sbs_pkg::CFG_MODULUS, {$urandom, $urandom});
        write_reg(sbs_pkg::CFG_BASE, {$urandom, $urandom});
        write_reg(sbs_pkg::CFG_SEED, {$urandom, $urandom});
      end
      pick = $urandom_range(0, 99);
      idx = 13'($urandom);
      if (draws_left > 0 && pick < 2) begin
        send_item(sbs_pkg::OP_DRAW, idx);
        draws_left--;
      end else if (pick < 40 && drawn_bins.size() != 0) begin
        idx = 13'(drawn_bins[$urandom_range(0, drawn_bins.size() - 1)]);
        send_item($urandom_range(0, 1) ? sbs_pkg::OP_READ : sbs_pkg::OP_CLEAR, idx);
      end else if (pick < 60) begin
        send_item(sbs_pkg::OP_READ, 13'($urandom_range(0, sbs_pkg::HIST_DEPTH + 3)));
      end else if (pick < 80) begin
        send_item(sbs_pkg::OP_CLEAR, idx);
      end else if (pick < 90) begin
        send_item(sbs_pkg::OP_READ, idx);
      end else begin
        send_item(OP_IDLE, idx);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        pause_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
      end else begin
        burst--;
      end
    end
    while (draws_left > 0) begin
      send_item(sbs_pkg::OP_DRAW, 13'($urandom));
      draws_left--;
    end
  endtask

  initial begin
    mod_reg = 10'd11;
    base_reg = -11'sd10;
    gen_state = '0;
    draw_total = '0;
    foreach (hist[i]) hist[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_reads();
    test_default_draw();
    test_extreme_draws();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
